/* rtl/core/fsgs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsgs_pkg
// Shared types, constants and helpers of the falling sand grid step block.
// ----------------------------------------------------------------------------
package fsgs_pkg;

  localparam int GridWidthDef  = 256;
  localparam int GridHeightDef = 256;
  localparam int COORD_W       = 12;   // signed grid coordinate, covers brush overhang
  localparam int COLOUR_W      = 24;
  localparam int RADIUS_W      = 5;
  localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
  localparam logic [31:0] LFSR_RESET = 32'd1;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd9;

  // request kinds
  localparam logic [1:0] REQ_PAINT = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // register indexes
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                present;
    logic                visited;
    logic [COLOUR_W-1:0] colour;
  } cell_t;

  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    lfsr_next = {1'b0, s[31:1]} ^ (s[0] ? LFSR_MASK : 32'd0);
  endfunction

  // draw mod 25 == 1, division by 25 through a reciprocal multiply
  function automatic logic draw_strict(input logic [31:0] v);
    logic [63:0] p;
    logic [31:0] q;
    logic [31:0] rem;
    p   = {32'd0, v} * 64'h0000_0000_51EB_851F;
    q   = {3'd0, p[63:35]};
    rem = v - (q * 32'd25);
    draw_strict = (rem == 32'd1);
  endfunction

endpackage

/* rtl/core/fsgs_grid_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsgs_grid_ram
// Cell store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fsgs_grid_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 26
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/falling_sand_grid_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_sand_grid_step_top
// Falling sand grid: paint, clear, sweep step and cell read over one cell RAM.
// ----------------------------------------------------------------------------
// Sequencing: a read passes ST_R_RD, ST_R_EV and ST_DONE; paint reads each
//   brush cell and fills it if empty; clear writes every cell; step reads each
//   cell of each column, runs fall tests and writes target and source of a move.
// Throughput: one item at a time; the sequencer and the single RAM port pair
//   set the rate, in_tready is high only between items.
// Reset: synchronous active low; afterwards a clearing pass over all 2^(XW+YW)
//   cells (65536 for 256x256) with in_tready low, configuration still taken.
module falling_sand_grid_step_top #(
  parameter int GRID_WIDTH  = fsgs_pkg::GridWidthDef,
  parameter int GRID_HEIGHT = fsgs_pkg::GridHeightDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pos_x[7:0], pos_y[15:8], paint_colour[39:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // cell_colour[23:0]
  output logic        out_tuser,  // cell_occupied
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fsgs_pkg::*;

  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int YW     = $clog2(GRID_HEIGHT);
  localparam int ADDR_W = XW + YW;
  localparam int CELL_W = $bits(cell_t);
  localparam coord_t WMAX = coord_t'(GRID_WIDTH - 1);
  localparam coord_t HMAX = coord_t'(GRID_HEIGHT - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_P_RD = 4'd2;
  localparam logic [3:0] ST_P_EV = 4'd3;
  localparam logic [3:0] ST_COL  = 4'd4;
  localparam logic [3:0] ST_S_RD = 4'd5;
  localparam logic [3:0] ST_S_EV = 4'd6;
  localparam logic [3:0] ST_T_IS = 4'd7;
  localparam logic [3:0] ST_T_EV = 4'd8;
  localparam logic [3:0] ST_MV_T = 4'd9;
  localparam logic [3:0] ST_MV_S = 4'd10;
  localparam logic [3:0] ST_S_NX = 4'd11;
  localparam logic [3:0] ST_R_RD = 4'd12;
  localparam logic [3:0] ST_R_EV = 4'd13;
  localparam logic [3:0] ST_DONE = 4'd14;

  function automatic logic in_grid(input coord_t x, input coord_t y);
    in_grid = (x >= 0) && (y >= 0) && (x <= WMAX) && (y <= HMAX);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input coord_t x, input coord_t y);
    cell_addr = {x[XW-1:0], y[YW-1:0]};
  endfunction

  logic [3:0]          state_r, state_nxt;
  logic                busy_r, busy_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  coord_t              i_r, i_nxt, j_r, j_nxt;       // sweep or paint cursor
  coord_t              x_r, x_nxt, y_r, y_nxt;       // request position
  coord_t              tx_r, tx_nxt, ty_r, ty_nxt;   // move target
  logic [COLOUR_W-1:0] colour_r, colour_nxt;
  cell_t               cur_r, cur_nxt;
  logic [1:0]          test_r, test_nxt;
  logic                left_r, left_nxt;
  logic                choice_r, choice_nxt;
  logic                src_vis_r, src_vis_nxt;
  logic [31:0]         lfsr_r, lfsr_nxt;
  logic                res_occ_r, res_occ_nxt;
  logic [COLOUR_W-1:0] res_col_r, res_col_nxt;
  logic                out_valid_r;
  logic                out_occ_r;
  logic [COLOUR_W-1:0] out_col_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [31:0]         seed_r;

  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  cell_t               wcell, rcell;
  logic [CELL_W-1:0]   rdata;

  logic                cfg_wr;
  logic                in_acc;
  coord_t              rad, tx_c, ty_c;
  logic                strict, free_c, go_right;

  fsgs_grid_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wcell),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rcell     = cell_t'(rdata);
  assign cfg_wr    = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SEED) ? seed_r
                                                 : {{(32-RADIUS_W){1'b0}}, radius_r};
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign rad       = coord_t'(radius_r);

  // current fall target: below, left-below, right-below
  always_comb begin
    ty_c = j_r + coord_t'(1);
    case (test_r)
      2'd1:    tx_c = i_r - coord_t'(1);
      2'd2:    tx_c = i_r + coord_t'(1);
      default: tx_c = i_r;
    endcase
  end

  assign strict   = draw_strict(lfsr_r);
  assign free_c   = in_grid(tx_c, ty_c) && !rcell.present && !(strict && rcell.visited);
  assign go_right = free_c && (!left_r || choice_r);

  always_comb begin
    state_nxt   = state_r;
    busy_nxt    = busy_r;
    clr_cnt_nxt = clr_cnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    tx_nxt      = tx_r;
    ty_nxt      = ty_r;
    colour_nxt  = colour_r;
    cur_nxt     = cur_r;
    test_nxt    = test_r;
    left_nxt    = left_r;
    choice_nxt  = choice_r;
    src_vis_nxt = src_vis_r;
    lfsr_nxt    = lfsr_r;
    res_occ_nxt = res_occ_r;
    res_col_nxt = res_col_r;
    we          = 1'b0;
    waddr       = cell_addr(i_r, j_r);
    wcell       = '0;
    raddr       = cell_addr(i_r, j_r);

    unique case (state_r) inside
      ST_IDLE: begin
        if (in_acc) begin
          busy_nxt    = 1'b1;
          res_occ_nxt = 1'b0;
          res_col_nxt = '0;
          x_nxt       = coord_t'(in_tdata[7:0]);
          y_nxt       = coord_t'(in_tdata[15:8]);
          colour_nxt  = in_tdata[39:16];
          unique case (in_tuser)
            REQ_PAINT: begin
              i_nxt     = coord_t'(in_tdata[7:0]) - rad;
              j_nxt     = coord_t'(in_tdata[15:8]) - rad;
              state_nxt = (radius_r == '0) ? ST_DONE : ST_P_RD;
            end
            REQ_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLR;
            end
            REQ_STEP: begin
              i_nxt     = WMAX;
              state_nxt = ST_COL;
            end
            default: begin
              state_nxt = ST_R_RD;
            end
          endcase
        end
      end
      ST_CLR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {ADDR_W{1'b1}}) begin
          state_nxt = busy_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_P_RD, ST_P_EV: begin
        if (state_r == ST_P_EV && !rcell.present) begin
          we    = 1'b1;
          wcell = '{present: 1'b1, visited: rcell.visited, colour: colour_r};
        end
        if (state_r == ST_P_RD && in_grid(i_r, j_r)) begin
          state_nxt = ST_P_EV;
        end else begin
          state_nxt = ST_P_RD;
          if (j_r + coord_t'(1) == y_r + rad) begin
            j_nxt = y_r - rad;
            i_nxt = i_r + coord_t'(1);
            if (i_r + coord_t'(1) == x_r + rad) begin
              state_nxt = ST_DONE;
            end
          end else begin
            j_nxt = j_r + coord_t'(1);
          end
        end
      end
      ST_COL: begin
        lfsr_nxt   = lfsr_next(lfsr_r);
        choice_nxt = lfsr_nxt[0];
        j_nxt      = HMAX;
        state_nxt  = ST_S_RD;
      end
      ST_S_RD: begin
        state_nxt = ST_S_EV;
      end
      ST_S_EV: begin
        cur_nxt = rcell;
        if (rcell.present && !rcell.visited) begin
          test_nxt  = 2'd0;
          state_nxt = ST_T_IS;
        end else begin
          we        = 1'b1;
          wcell     = '{present: rcell.present, visited: 1'b0, colour: rcell.colour};
          state_nxt = ST_S_NX;
        end
      end
      ST_T_IS: begin
        lfsr_nxt  = lfsr_next(lfsr_r);
        raddr     = cell_addr(tx_c, ty_c);
        state_nxt = ST_T_EV;
      end
      ST_T_EV: begin
        if (test_r == 2'd0) begin
          if (free_c) begin
            tx_nxt      = tx_c;
            ty_nxt      = ty_c;
            src_vis_nxt = 1'b1;
            state_nxt   = ST_MV_T;
          end else begin
            test_nxt  = 2'd1;
            state_nxt = ST_T_IS;
          end
        end else if (test_r == 2'd1) begin
          left_nxt  = free_c;
          test_nxt  = 2'd2;
          state_nxt = ST_T_IS;
        end else begin
          src_vis_nxt = 1'b0;
          tx_nxt      = go_right ? i_r + coord_t'(1) : i_r - coord_t'(1);
          ty_nxt      = ty_c;
          if (left_r || free_c) begin
            state_nxt = ST_MV_T;
          end else begin
            we        = 1'b1;
            wcell     = '{present: 1'b1, visited: 1'b0, colour: cur_r.colour};
            state_nxt = ST_S_NX;
          end
        end
      end
      ST_MV_T: begin
        we        = 1'b1;
        waddr     = cell_addr(tx_r, ty_r);
        wcell     = '{present: 1'b1, visited: 1'b1, colour: cur_r.colour};
        state_nxt = ST_MV_S;
      end
      ST_MV_S: begin
        we        = 1'b1;
        wcell     = '{present: 1'b0, visited: src_vis_r, colour: '0};
        state_nxt = ST_S_NX;
      end
      ST_S_NX: begin
        if (j_r == coord_t'(0)) begin
          if (i_r == coord_t'(0)) begin
            state_nxt = ST_DONE;
          end else begin
            i_nxt     = i_r - coord_t'(1);
            state_nxt = ST_COL;
          end
        end else begin
          j_nxt     = j_r - coord_t'(1);
          state_nxt = ST_S_RD;
        end
      end
      ST_R_RD: begin
        raddr     = cell_addr(x_r, y_r);
        state_nxt = in_grid(x_r, y_r) ? ST_R_EV : ST_DONE;
      end
      ST_R_EV: begin
        res_occ_nxt = rcell.present;
        res_col_nxt = rcell.present ? rcell.colour : '0;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          busy_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr && cfg_paddr[2] == REG_SEED) begin
      lfsr_nxt = (cfg_pwdata == 32'd0) ? LFSR_RESET : cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      busy_r      <= 1'b0;
      clr_cnt_r   <= '0;
      lfsr_r      <= LFSR_RESET;
      radius_r    <= RADIUS_RESET;
      seed_r      <= LFSR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      busy_r    <= busy_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      lfsr_r    <= lfsr_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_RADIUS) begin
          radius_r <= cfg_pwdata[RADIUS_W-1:0];
        end else begin
          seed_r <= cfg_pwdata;
        end
      end
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    tx_r      <= tx_nxt;
    ty_r      <= ty_nxt;
    colour_r  <= colour_nxt;
    cur_r     <= cur_nxt;
    test_r    <= test_nxt;
    left_r    <= left_nxt;
    choice_r  <= choice_nxt;
    src_vis_r <= src_vis_nxt;
    res_occ_r <= res_occ_nxt;
    res_col_r <= res_col_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_occ_r <= res_occ_r;
      out_col_r <= res_col_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_occ_r;
  assign out_tdata  = out_col_r;

endmodule

/* rtl/core/fsgs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsgs_checker
// Port-level checks of the falling sand grid step block.
// ----------------------------------------------------------------------------
module fsgs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_pready
);

  // clearing pass keeps the input closed right after reset
  a_reset_closed: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input open during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // an empty cell reads as colour zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 24'd0)
    else $error("empty cell with colour");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind falling_sand_grid_step_top fsgs_checker u_fsgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

/* tb/falling_sand_grid_step_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_sand_grid_step_top_tb
// Self-checking bench: paint, clear, step and read items go through a bursty
// driver. A local grid model predicts every result. Results are compared in
// order against that prediction while the receiver stalls.
// ----------------------------------------------------------------------------
module falling_sand_grid_step_top_tb;
  import fsgs_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [23:0] colour;
  } sand_req_t;

  typedef struct packed {
    logic        occupied;
    logic [23:0] colour;
  } cell_read_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // pos_x[7:0], pos_y[15:8], paint_colour[39:16]
  logic [1:0]  in_tuser = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // cell_colour[23:0]
  logic        out_tuser;       // cell_occupied
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  falling_sand_grid_step_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------- grid model ----------------
  bit          grid_full [65536];
  bit          grid_seen [65536];
  logic [23:0] grid_rgb  [65536];
  logic [31:0] lfsr_q;
  int          radius_q;

  sand_req_t  pending_reqs[$];
  cell_read_t expected_reads[$];
  int         mismatches = 0;

  function automatic logic [31:0] next_draw();
    lfsr_q = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? 32'h8020_0003 : 32'd0);
    return lfsr_q;
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < 256 && y < 256;
  endfunction

  function automatic bit cell_free(int x, int y);
    bit strict;
    int c;
    strict = (next_draw() % 25) == 1;
    if (!on_grid(x, y)) return 0;
    c = x * 256 + y;
    if (grid_full[c]) return 0;
    return !(strict && grid_seen[c]);
  endfunction

  function automatic void shift_grain(int src, int dst);
    grid_full[dst] = 1;
    grid_seen[dst] = grid_seen[src];
    grid_rgb[dst]  = grid_rgb[src];
    grid_full[src] = 0;
    grid_rgb[src]  = '0;
  endfunction

  function automatic void sweep_grid();
    bit choice, lft, rgt;
    int c;
    for (int i = 255; i >= 0; i--) begin
      choice = next_draw() % 2 == 1;
      for (int j = 255; j >= 0; j--) begin
        c = i * 256 + j;
        if (!grid_seen[c] && grid_full[c]) begin
          grid_seen[c] = 1;
          if (cell_free(i, j + 1)) begin
            shift_grain(c, c + 1);
            continue;   // straight fall keeps the mark
          end
          lft = cell_free(i - 1, j + 1);
          rgt = cell_free(i + 1, j + 1);
          if (lft && rgt) begin
            if (choice) lft = 0;
            else rgt = 0;
          end
          if (lft) shift_grain(c, (i - 1) * 256 + j + 1);
          else if (rgt) shift_grain(c, (i + 1) * 256 + j + 1);
        end
        grid_seen[c] = 0;
      end
    end
  endfunction

  function automatic cell_read_t apply_req(sand_req_t r);
    cell_read_t res;
    int c;
    res = '0;
    case (r.kind)
      REQ_PAINT: begin
        for (int bx = int'(r.x) - radius_q; bx < int'(r.x) + radius_q; bx++)
          for (int by = int'(r.y) - radius_q; by < int'(r.y) + radius_q; by++)
            if (on_grid(bx, by)) begin
              c = bx * 256 + by;
              if (!grid_full[c]) begin
                grid_full[c] = 1;
                grid_rgb[c]  = r.colour;
              end
            end
      end
      REQ_CLEAR: begin
        for (int k = 0; k < 65536; k++) begin
          grid_full[k] = 0;
          grid_seen[k] = 0;
          grid_rgb[k]  = '0;
        end
      end
      REQ_STEP: sweep_grid();
      default: begin
        c = int'(r.x) * 256 + int'(r.y);
        if (grid_full[c]) begin
          res.occupied = 1'b1;
          res.colour   = grid_rgb[c];
        end
      end
    endcase
    return res;
  endfunction

  // ---------------- driver ----------------
  bit in_taken = 0;
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (in_tvalid && in_tready)
      expected_reads = {expected_reads,
                        apply_req(sand_req_t'({in_tuser, in_tdata[7:0],
                                               in_tdata[15:8], in_tdata[39:16]}))};
  end

  always @(negedge clk) begin
    sand_req_t r;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= r.kind;
        in_tdata  <= {r.colour, r.y, r.x};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  bit long_hold_req = 0;
  int hold_left = 0;
  int stall_mode = 0;

  always @(negedge clk) begin
    if (long_hold_req && hold_left == 0) begin
      hold_left = 400;
      long_hold_req = 0;
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 3) != 0;
        default: out_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk) begin
    cell_read_t want;
    if (out_tvalid && out_tready) begin
      if (expected_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: occupied %0b colour %06h", out_tuser, out_tdata);
      end else begin
        want = expected_reads.pop_front();
        if (out_tuser !== want.occupied || out_tdata !== want.colour) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected occupied %0b colour %06h, got %0b %06h",
                     want.occupied, want.colour, out_tuser, out_tdata);
        end
      end
    end
  end

  // ---------------- sequencing ----------------
  task automatic reg_write(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_RADIUS) radius_q = int'(val[4:0]);
    else lfsr_q = (val == 0) ? 32'd1 : val;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_reads.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic add_req(logic [1:0] k, int x, int y, logic [23:0] col);
    sand_req_t r;
    r = '{k, 8'(x), 8'(y), col};
    pending_reqs = {pending_reqs, r};
  endtask

  // mostly paint and reads near recent strokes; at most one step and one clear
  task automatic add_random(int count, int steps, int clears);
    int px, py, k;
    px = $urandom_range(0, 255);
    py = $urandom_range(0, 255);
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (n == count / 2 && steps > 0) begin
        add_req(REQ_STEP, $urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
        steps--;
      end else if (n == count - 3 && clears > 0) begin
        add_req(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
        clears--;
      end else if (k < 30) begin
        px = $urandom_range(0, 255);
        py = $urandom_range(0, 255);
        add_req(REQ_PAINT, px, py, 24'($urandom));
      end else if (k < 85) begin
        add_req(REQ_READ, (px + $urandom_range(0, 40) - 20) & 255,
                (py + $urandom_range(0, 40) - 20) & 255, 24'($urandom));
      end else begin
        add_req(REQ_READ, $urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
      end
    end
  endtask

  initial begin
    for (int k = 0; k < 65536; k++) begin
      grid_full[k] = 0;
      grid_seen[k] = 0;
      grid_rgb[k]  = '0;
    end
    lfsr_q = 32'd1;
    radius_q = 9;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, edges, every request kind, reset settings
    add_req(REQ_PAINT, 0, 0, 24'hFFFFFF);
    add_req(REQ_PAINT, 255, 255, 24'h000000);
    add_req(REQ_PAINT, 128, 240, 24'h5A5AA5);
    add_req(REQ_READ, 0, 0, 24'hFFFFFF);
    add_req(REQ_READ, 8, 8, 24'h0);
    add_req(REQ_READ, 9, 0, 24'h0);
    add_req(REQ_READ, 255, 255, 24'h0);
    add_req(REQ_READ, 246, 246, 24'h0);
    add_req(REQ_READ, 119, 231, 24'h0);
    add_req(REQ_READ, 100, 100, 24'h0);
    add_req(REQ_STEP, 255, 255, 24'hFFFFFF);
    add_req(REQ_READ, 128, 248, 24'h0);
    add_req(REQ_READ, 128, 231, 24'h0);
    add_req(REQ_READ, 0, 18, 24'h0);
    add_req(REQ_READ, 137, 249, 24'h0);
    add_req(REQ_CLEAR, 0, 0, 24'h0);
    add_req(REQ_READ, 0, 0, 24'h0);
    add_req(REQ_READ, 128, 255, 24'h0);
    wait_drained();

    // largest brush, all-ones seed; receiver held off for a long stretch
    reg_write(REG_RADIUS, 32'd31);
    reg_write(REG_SEED, 32'hFFFF_FFFF);
    long_hold_req = 1;
    add_random(35, 1, 0);
    wait_drained();

    // empty brush, zero seed falls back to one
    reg_write(REG_RADIUS, 32'd0);
    reg_write(REG_SEED, 32'd0);
    add_req(REQ_PAINT, 50, 50, 24'h123456);
    add_req(REQ_READ, 50, 50, 24'h0);
    add_random(8, 0, 0);
    wait_drained();

    reg_write(REG_RADIUS, $urandom_range(1, 31));
    reg_write(REG_SEED, $urandom);
    add_random(45, 1, 1);
    wait_drained();

    if (mismatches == 0)
      $display("falling_sand_grid_step_top_tb OK");
    else
      $display("falling_sand_grid_step_top_tb NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("falling_sand_grid_step_top_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/core/fsgs_pkg.sv
rtl/core/fsgs_grid_ram.sv
rtl/core/falling_sand_grid_step_top.sv
rtl/core/fsgs_checker.sv
tb/falling_sand_grid_step_top_tb.sv
